// ----- src/msc_pkg.sv -----
// Shared types and constants for the memory serial configuration port.
`timescale 1ns / 1ps
`default_nettype none
package msc_pkg;

  localparam logic [31:0] CMD_WINDOW  = 32'h1000_F430;
  localparam logic [31:0] DATA_WINDOW = 32'h1000_F440;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NODEV   = 3'd1;
  localparam logic [2:0] ST_BADADDR = 3'd2;
  localparam logic [2:0] ST_BADOP   = 3'd3;
  localparam logic [2:0] ST_BADREG  = 3'd4;
  localparam logic [2:0] ST_BADFORM = 3'd5;

  localparam logic [3:0] OP_SREAD  = 4'h0;
  localparam logic [3:0] OP_SWRITE = 4'h1;
  localparam logic [3:0] OP_NOP_A  = 4'h2;
  localparam logic [3:0] OP_NOP_B  = 4'h4;
  localparam logic [3:0] OP_NOP_C  = 4'hB;
  localparam logic [3:0] OP_NOP_D  = 4'hE;

  localparam logic [11:0] REG_INIT   = 12'h021;
  localparam logic [11:0] REG_TEST0  = 12'h022;
  localparam logic [11:0] REG_DEVID  = 12'h040;
  localparam logic [11:0] REG_CCA    = 12'h043;
  localparam logic [11:0] REG_CCB    = 12'h044;
  localparam logic [11:0] REG_NAPX   = 12'h045;
  localparam logic [11:0] REG_PDNXA  = 12'h046;
  localparam logic [11:0] REG_PDNX   = 12'h047;
  localparam logic [11:0] REG_TPARM  = 12'h048;
  localparam logic [11:0] REG_TFRM1  = 12'h049;
  localparam logic [11:0] REG_TCDLY1 = 12'h04A;
  localparam logic [11:0] REG_SKIP   = 12'h04B;
  localparam logic [11:0] REG_TCYCLE = 12'h04C;
  localparam logic [11:0] REG_TEST1  = 12'h04D;
  localparam logic [11:0] REG_TEST2  = 12'h04E;

  // what to do once the device lookup finishes
  localparam logic [1:0] PEND_RD_INIT  = 2'd0;
  localparam logic [1:0] PEND_RD_DEVID = 2'd1;
  localparam logic [1:0] PEND_WR_INIT  = 2'd2;
  localparam logic [1:0] PEND_WR_DEVID = 2'd3;

  localparam logic [5:0] SERIAL_ID_RESET = 6'h3F;
  localparam logic [6:0] INIT_FLAGS_RESET = 7'h02;

  typedef struct packed {
    logic        kind;
    logic [31:0] address;
    logic [31:0] write_data;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [2:0]  status;
  } rsp_t;

  typedef struct packed {
    logic busy;
    logic hit;
    logic miss;
  } scan_st_t;

  typedef struct packed {
    logic        init_all;
    logic        init_one;
    logic        ident_one;
    logic        bcast;
    logic [11:0] reg_addr;
    logic [15:0] data;
  } dev_wr_t;

endpackage
`default_nettype wire

// ----- src/msc_stream_if.sv -----
// Valid/ready stream channel carrying one payload per beat.
`timescale 1ns / 1ps
`default_nettype none
interface msc_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- src/msc_dev_regs.sv -----
// Per-device control register file with one indexed read port.
`timescale 1ns / 1ps
`default_nettype none
module msc_dev_regs #(
  parameter int NUM_DEVICES = 2,
  localparam int IDX_W = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [IDX_W-1:0] idx,
  input  wire msc_pkg::dev_wr_t wr,
  output logic [5:0]            rd_serial_id,
  output logic [31:0]           rd_init_word,
  output logic [4:0]            rd_ident
);

  logic [5:0]  serial_id  [NUM_DEVICES];
  logic [6:0]  init_flags [NUM_DEVICES];
  logic [4:0]  ident      [NUM_DEVICES];
  logic [7:0]  cca        [NUM_DEVICES];
  logic [7:0]  ccb        [NUM_DEVICES];
  logic [10:0] napx       [NUM_DEVICES];
  logic [5:0]  pdnxa      [NUM_DEVICES];
  logic [2:0]  pdnx       [NUM_DEVICES];
  logic [6:0]  tparm      [NUM_DEVICES];
  logic [3:0]  tfrm       [NUM_DEVICES];
  logic [1:0]  tcdly      [NUM_DEVICES];
  logic [12:0] skip       [NUM_DEVICES];
  logic [5:0]  tcycle     [NUM_DEVICES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DEVICES; i++) begin
        serial_id[i]  <= msc_pkg::SERIAL_ID_RESET;
        init_flags[i] <= msc_pkg::INIT_FLAGS_RESET;
        ident[i]      <= '0;
        cca[i]        <= '0;
        ccb[i]        <= '0;
        napx[i]       <= '0;
        pdnxa[i]      <= '0;
        pdnx[i]       <= '0;
        tparm[i]      <= '0;
        tfrm[i]       <= '0;
        tcdly[i]      <= '0;
        skip[i]       <= '0;
        tcycle[i]     <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_DEVICES; i++) begin
        if (wr.init_all || (wr.init_one && idx == IDX_W'(i))) begin
          // id bit 5 rides on word bit 14; word bit 10 is dropped
          serial_id[i]  <= {wr.data[14], wr.data[4:0]};
          init_flags[i] <= {wr.data[13:11], wr.data[9:6]};
        end
        if (wr.ident_one && idx == IDX_W'(i)) begin
          ident[i] <= wr.data[4:0];
        end
        if (wr.bcast) begin
          unique case (wr.reg_addr)
            msc_pkg::REG_CCA:    cca[i]    <= wr.data[7:0];
            msc_pkg::REG_CCB:    ccb[i]    <= wr.data[7:0];
            msc_pkg::REG_NAPX:   napx[i]   <= wr.data[10:0];
            msc_pkg::REG_PDNXA:  pdnxa[i]  <= wr.data[5:0];
            msc_pkg::REG_PDNX:   pdnx[i]   <= wr.data[2:0];
            msc_pkg::REG_TPARM:  tparm[i]  <= wr.data[6:0];
            msc_pkg::REG_TFRM1:  tfrm[i]   <= wr.data[3:0];
            msc_pkg::REG_TCDLY1: tcdly[i]  <= wr.data[1:0];
            msc_pkg::REG_SKIP:   skip[i]   <= {wr.data[12], 1'b0, wr.data[10:8], 8'h00};
            msc_pkg::REG_TCYCLE: tcycle[i] <= wr.data[5:0];
            default: ;
          endcase
        end
      end
    end
  end

  always_comb begin
    rd_serial_id = serial_id[idx];
    rd_ident     = ident[idx];
    rd_init_word = {17'h0, serial_id[idx][5], init_flags[idx][6:4], 1'b0,
                    init_flags[idx][3:0], 1'b0, serial_id[idx][4:0]};
  end

endmodule
`default_nettype wire

// ----- src/msc_scan.sv -----
// Device lookup sequencer: one shared id comparator stepped over the devices.
`timescale 1ns / 1ps
`default_nettype none
module msc_scan #(
  parameter int NUM_DEVICES = 2,
  localparam int IDX_W = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [5:0]        dev_id,
  input  wire logic [5:0]        rd_serial_id,
  output logic [IDX_W-1:0]       idx,
  output msc_pkg::scan_st_t      st
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_DEVICES - 1);

  logic             state;
  logic             state_next;
  logic [IDX_W-1:0] idx_next;
  logic [5:0]       target;
  logic             match;

  assign match   = (rd_serial_id == target);
  assign st.busy = (state == S_SCAN);
  assign st.hit  = (state == S_SCAN) && match;
  assign st.miss = (state == S_SCAN) && !match && (idx == LAST_IDX);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_SCAN;
          idx_next   = '0;
        end
      end
      S_SCAN: begin
        if (match || idx == LAST_IDX) begin
          state_next = S_IDLE;
        end else begin
          idx_next = idx + IDX_W'(1);
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && state == S_IDLE) begin
      target <= dev_id;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    idx <= LAST_IDX)
    else $error("lookup index past last device");

  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == S_IDLE)
    else $error("lookup started while one is running");

  a_scan_ends_once: assert property (@(posedge clk) disable iff (rst)
    (st.hit || st.miss) |=> state == S_IDLE)
    else $error("lookup kept running after its result");

endmodule
`default_nettype wire

// ----- src/memory_serial_config_port.sv -----
// Top level of the memory serial configuration port.
//
//   channel  dir  beat payload                 handshake
//   req      in   kind, address, write_data    req.valid & req.ready
//   rsp      out  read_data, status            rsp.valid & rsp.ready
//
// Bus reads, data window writes and commands that need no lookup: result
// registered in the cycle after the beat. Commands that name a single device
// (serial reads, unicast INIT and DEVID writes) run the shared id comparator
// one device per cycle, stopping at the first match or after the last device.
// req.ready is low during a lookup and while a result sits unaccepted in the
// output register. Synchronous reset loads the state, control and readback
// registers; the output data register and lookup target have no reset.
`timescale 1ns / 1ps
`default_nettype none
module memory_serial_config_port #(
  parameter int NUM_DEVICES = 2
) (
  input wire logic    clk,
  input wire logic    rst,
  msc_stream_if.sink   req,
  msc_stream_if.source rsp
);

  localparam int IDX_W = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;

  logic [15:0] serial_data;
  logic [31:0] readback;
  logic [1:0]  pend;

  logic             rsp_valid;
  msc_pkg::rsp_t    rsp_data;

  logic             accept;
  logic             take;
  msc_pkg::scan_st_t scan_st;
  logic [IDX_W-1:0] idx;
  msc_pkg::dev_wr_t wr;
  logic [5:0]       rd_serial_id;
  logic [31:0]      rd_init_word;
  logic [4:0]       rd_ident;

  // command word fields
  logic [11:0] cmd_reg;
  logic [5:0]  cmd_dev;
  logic [3:0]  cmd_op;
  logic        cmd_bc;

  logic        dec_scan;
  logic [1:0]  dec_pend;
  logic [2:0]  dec_status;
  logic [31:0] dec_rdata;
  logic        dec_latch;
  logic        dec_init_all;
  logic        dec_bcast;

  assign cmd_reg = req.payload.write_data[27:16];
  assign cmd_dev = {req.payload.write_data[10], req.payload.write_data[4:0]};
  assign cmd_op  = req.payload.write_data[9:6];
  assign cmd_bc  = req.payload.write_data[5];

  assign take      = rsp_valid && rsp.ready;
  assign req.ready = !scan_st.busy && (!rsp_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  always_comb begin
    dec_scan     = 1'b0;
    dec_pend     = msc_pkg::PEND_RD_INIT;
    dec_status   = msc_pkg::ST_OK;
    dec_rdata    = '0;
    dec_latch    = 1'b0;
    dec_init_all = 1'b0;
    dec_bcast    = 1'b0;
    if (req.payload.address == msc_pkg::DATA_WINDOW) begin
      if (req.payload.kind == msc_pkg::KIND_READ) begin
        dec_rdata = readback;
      end else begin
        dec_latch = 1'b1;
      end
    end else if (req.payload.address != msc_pkg::CMD_WINDOW) begin
      dec_status = msc_pkg::ST_BADADDR;
    end else if (req.payload.kind == msc_pkg::KIND_WRITE) begin
      unique case (cmd_op) inside
        msc_pkg::OP_SREAD: begin
          if (cmd_reg == msc_pkg::REG_INIT) begin
            dec_scan = 1'b1;
            dec_pend = msc_pkg::PEND_RD_INIT;
          end else if (cmd_reg == msc_pkg::REG_DEVID) begin
            dec_scan = 1'b1;
            dec_pend = msc_pkg::PEND_RD_DEVID;
          end else begin
            dec_status = msc_pkg::ST_BADREG;
          end
        end
        msc_pkg::OP_SWRITE: begin
          unique case (cmd_reg) inside
            msc_pkg::REG_TEST0, msc_pkg::REG_TEST1, msc_pkg::REG_TEST2: ;
            msc_pkg::REG_INIT: begin
              if (cmd_bc) begin
                dec_init_all = 1'b1;
              end else begin
                dec_scan = 1'b1;
                dec_pend = msc_pkg::PEND_WR_INIT;
              end
            end
            msc_pkg::REG_DEVID: begin
              if (cmd_bc) begin
                dec_status = msc_pkg::ST_BADFORM;
              end else begin
                dec_scan = 1'b1;
                dec_pend = msc_pkg::PEND_WR_DEVID;
              end
            end
            [msc_pkg::REG_CCA:msc_pkg::REG_TCYCLE]: begin
              if (cmd_bc) begin
                dec_bcast = 1'b1;
              end else begin
                dec_status = msc_pkg::ST_BADFORM;
              end
            end
            default: dec_status = msc_pkg::ST_BADREG;
          endcase
        end
        msc_pkg::OP_NOP_A, msc_pkg::OP_NOP_B, msc_pkg::OP_NOP_C, msc_pkg::OP_NOP_D: ;
        default: dec_status = msc_pkg::ST_BADOP;
      endcase
    end
  end

  msc_scan #(
    .NUM_DEVICES(NUM_DEVICES)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .start        (accept && dec_scan),
    .dev_id       (cmd_dev),
    .rd_serial_id (rd_serial_id),
    .idx          (idx),
    .st           (scan_st)
  );

  always_comb begin
    wr.init_all  = accept && dec_init_all;
    wr.bcast     = accept && dec_bcast;
    wr.init_one  = scan_st.hit && (pend == msc_pkg::PEND_WR_INIT);
    wr.ident_one = scan_st.hit && (pend == msc_pkg::PEND_WR_DEVID);
    wr.reg_addr  = cmd_reg;
    wr.data      = serial_data;
  end

  msc_dev_regs #(
    .NUM_DEVICES(NUM_DEVICES)
  ) u_regs (
    .clk          (clk),
    .rst          (rst),
    .idx          (idx),
    .wr           (wr),
    .rd_serial_id (rd_serial_id),
    .rd_init_word (rd_init_word),
    .rd_ident     (rd_ident)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      serial_data <= '0;
      readback    <= '0;
      pend        <= msc_pkg::PEND_RD_INIT;
    end else begin
      if (accept && dec_latch) begin
        serial_data <= req.payload.write_data[15:0];
      end
      if (accept && dec_scan) begin
        pend <= dec_pend;
      end
      if (scan_st.hit || scan_st.miss) begin
        unique case (pend)
          msc_pkg::PEND_RD_INIT:  readback <= scan_st.hit ? rd_init_word : '0;
          msc_pkg::PEND_RD_DEVID: readback <= scan_st.hit ? {27'h0, rd_ident} : '0;
          default: ;
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((accept && !dec_scan) || scan_st.hit || scan_st.miss) begin
      rsp_valid <= 1'b1;
    end else if (take) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !dec_scan) begin
      rsp_data.read_data <= dec_rdata;
      rsp_data.status    <= dec_status;
    end else if (scan_st.hit || scan_st.miss) begin
      rsp_data.read_data <= '0;
      rsp_data.status    <= scan_st.hit ? msc_pkg::ST_OK : msc_pkg::ST_NODEV;
    end
  end

  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_data;

  a_no_accept_in_lookup: assert property (@(posedge clk) disable iff (rst)
    scan_st.busy |-> !req.ready)
    else $error("beat taken during device lookup");

  a_error_reads_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status != msc_pkg::ST_OK |-> rsp_data.read_data == '0)
    else $error("error beat carries read data");

  a_status_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_data.status <= msc_pkg::ST_BADFORM)
    else $error("status code out of range");

  a_result_has_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(accept && !dec_scan) || $past(scan_st.hit || scan_st.miss))
    else $error("result appeared without a request");

endmodule
`default_nettype wire
